@@ src/brpd_pkg.sv @@
package brpd_pkg;

  // Default geometry
  localparam int DEF_PERIOD_WIDTH      = 10;
  localparam int DEF_PRESS_COUNT_WIDTH = 16;

  // Fixed register width
  localparam int RAMP_DIV_W = 8;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD_TICKS       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS_PERIODS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_DIVIDER       = 2'd2;

  // Reset values of the configuration registers
  localparam int RST_PERIOD_TICKS       = 200;
  localparam int RST_LONG_PRESS_PERIODS = 100;
  localparam int RST_RAMP_DIVIDER       = 2;

  // Reset duty in ticks
  localparam int RST_DUTY_TICKS = 1;

  typedef enum logic [1:0] {
    RAMP_IDLE = 2'd0,
    RAMP_UP   = 2'd1,
    RAMP_DOWN = 2'd2
  } ramp_mode_t;

endpackage

@@ src/brpd_cfg.sv @@
module brpd_cfg import brpd_pkg::*; #(
  parameter int PERIOD_WIDTH      = DEF_PERIOD_WIDTH,
  parameter int PRESS_COUNT_WIDTH = DEF_PRESS_COUNT_WIDTH,
  parameter int CFG_DATA_W        = DEF_PRESS_COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic [PERIOD_WIDTH-1:0]      period_ticks,
  output logic [PRESS_COUNT_WIDTH-1:0] long_press_periods,
  output logic [RAMP_DIV_W-1:0]        ramp_divider
);

  // Write one register per enabled cycle; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks       <= PERIOD_WIDTH'(RST_PERIOD_TICKS);
      long_press_periods <= PRESS_COUNT_WIDTH'(RST_LONG_PRESS_PERIODS);
      ramp_divider       <= RAMP_DIV_W'(RST_RAMP_DIVIDER);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PERIOD_TICKS:       period_ticks       <= cfg_data[PERIOD_WIDTH-1:0];
        CFG_LONG_PRESS_PERIODS: long_press_periods <= cfg_data[PRESS_COUNT_WIDTH-1:0];
        CFG_RAMP_DIVIDER:       ramp_divider       <= cfg_data[RAMP_DIV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/brpd_core.sv @@
module brpd_core import brpd_pkg::*; #(
  parameter int PERIOD_WIDTH      = DEF_PERIOD_WIDTH,
  parameter int PRESS_COUNT_WIDTH = DEF_PRESS_COUNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_accept,
  input  logic                         button,
  input  logic [PERIOD_WIDTH-1:0]      period_ticks,
  input  logic [PRESS_COUNT_WIDTH-1:0] long_press_periods,
  input  logic [RAMP_DIV_W-1:0]        ramp_divider,
  // led_on, brightness, ramp_mode from the lowest bit up
  output logic [PERIOD_WIDTH+2:0]      result
);

  logic [PERIOD_WIDTH-1:0]      tick_pos, tick_pos_next;
  logic [PERIOD_WIDTH-1:0]      duty, duty_next;
  logic [PRESS_COUNT_WIDTH-1:0] press, press_next;
  logic                         up, up_next;
  logic                         down, down_next;
  logic [RAMP_DIV_W-1:0]        ramp_count, ramp_count_next;
  logic [RAMP_DIV_W-1:0]        ramp_inc;
  logic [PERIOD_WIDTH:0]        pos_inc;
  logic                         period_end;
  logic                         led;
  ramp_mode_t                   mode;

  // Period timing, button handling and ramp stepping for one tick
  always_comb begin
    pos_inc         = {1'b0, tick_pos} + 1'b1;
    period_end      = pos_inc >= {1'b0, period_ticks};
    led             = tick_pos < duty;
    tick_pos_next   = period_end ? '0 : pos_inc[PERIOD_WIDTH-1:0];
    press_next      = press;
    up_next         = up;
    down_next       = down;
    ramp_count_next = ramp_count;
    duty_next       = duty;
    ramp_inc        = '0;
    if (period_end) begin
      // Count held periods, act on release
      if (button) begin
        if (press != '1) press_next = press + 1'b1;
      end else if (press != '0) begin
        if (up || down) begin
          up_next   = 1'b0;
          down_next = 1'b0;
        end else if (press > long_press_periods) begin
          down_next = 1'b1;
        end else begin
          up_next = 1'b1;
        end
        press_next = '0;
      end
      // Step the duty every ramp_divider periods; stop at the range ends
      if (up_next || down_next) begin
        ramp_inc        = ramp_count + 1'b1;
        ramp_count_next = ramp_inc;
        if (ramp_inc == ramp_divider) begin
          if (up_next) begin
            if (duty < period_ticks) duty_next = duty + 1'b1;
            else up_next = 1'b0;
          end else begin
            if (duty != '0) duty_next = duty - 1'b1;
            else down_next = 1'b0;
          end
          ramp_count_next = '0;
        end
      end
    end
  end

  // Encode the ramp mode after this tick
  always_comb begin
    priority if (up_next) mode = RAMP_UP;
    else if (down_next)   mode = RAMP_DOWN;
    else                  mode = RAMP_IDLE;
  end

  assign result = {mode, duty_next, led};

  // Advance state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_pos   <= '0;
      duty       <= PERIOD_WIDTH'(RST_DUTY_TICKS);
      press      <= '0;
      up         <= 1'b0;
      down       <= 1'b0;
      ramp_count <= '0;
    end else if (in_accept) begin
      tick_pos   <= tick_pos_next;
      duty       <= duty_next;
      press      <= press_next;
      up         <= up_next;
      down       <= down_next;
      ramp_count <= ramp_count_next;
    end
  end

`ifndef SYNTH
  a_one_direction: assert property (@(posedge clk) disable iff (rst) !(up && down))
    else $error("ramp up and ramp down both active");
  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    in_accept && !period_end |=> tick_pos == $past(tick_pos) + 1'b1)
    else $error("tick position did not advance");
  a_duty_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_accept && period_end) |=> $stable(duty))
    else $error("duty changed outside a period end");
`endif

endmodule

@@ src/brpd_skid.sv @@
module brpd_skid #(
  parameter int DATA_W = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              skid_valid;
  logic [DATA_W-1:0] skid_data;
  logic              accept;
  logic              out_free;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Control: refill the output stage, park an item in the skid on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (accept) begin
      skid_data <= in_data;
    end
  end

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output stage is empty");
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> out_valid && !skid_valid)
    else $error("skid item not moved to the output stage");
  a_stall_park: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && accept |=> skid_valid && out_valid)
    else $error("item accepted on stall was not parked");
`endif

endmodule

@@ src/button_ramped_pwm_dimmer.sv @@
// Single-button PWM LED dimmer.
// Input stream: one item per base tick of the PWM timebase; s_tdata[0] is the
// button level (1 pressed), looked at only on the last tick of each period.
// Output stream: one item per input item, in order: the LED level for that
// tick, the duty (brightness) after the tick and the ramp mode
// (0 idle, 1 ramping up, 2 ramping down).
// Configuration: cfg_we with cfg_addr 0 period_ticks, 1 long_press_periods,
// 2 ramp_divider; write only while no item is in flight.
// Throughput: one item per clock while s_tready is high. The tick counter, press
// counter and ramp logic update at the input, so a new item can follow at once.
// Output: the result is registered in the output stage, or in the skid on stall.
// Stall: an output register plus a one-entry skid stage keep results; with
// both full s_tready drops until the receiver takes an item. Nothing is lost.
// Reset (rst, synchronous): registers return to 200 / 100 / 2, duty to one
// tick, counters to zero, no ramp; no item is pending afterwards.
module button_ramped_pwm_dimmer import brpd_pkg::*; #(
  parameter int PERIOD_WIDTH      = DEF_PERIOD_WIDTH,
  parameter int PRESS_COUNT_WIDTH = DEF_PRESS_COUNT_WIDTH,
  localparam int RES_W      = PERIOD_WIDTH + 3,
  localparam int OUT_W      = ((RES_W + 7) / 8) * 8,
  localparam int CFG_DATA_W = (PERIOD_WIDTH > PRESS_COUNT_WIDTH) ?
                              PERIOD_WIDTH : PRESS_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // button
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // led_on, brightness, ramp_mode
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PERIOD_WIDTH-1:0]      period_ticks;
  logic [PRESS_COUNT_WIDTH-1:0] long_press_periods;
  logic [RAMP_DIV_W-1:0]        ramp_divider;
  logic [RES_W-1:0]             result;
  logic [RES_W-1:0]             out_res;
  logic                         accept;

  assign accept = s_tvalid && s_tready;

  brpd_cfg #(
    .PERIOD_WIDTH      (PERIOD_WIDTH),
    .PRESS_COUNT_WIDTH (PRESS_COUNT_WIDTH),
    .CFG_DATA_W        (CFG_DATA_W)
  ) u_cfg (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_data           (cfg_data),
    .period_ticks       (period_ticks),
    .long_press_periods (long_press_periods),
    .ramp_divider       (ramp_divider)
  );

  brpd_core #(
    .PERIOD_WIDTH      (PERIOD_WIDTH),
    .PRESS_COUNT_WIDTH (PRESS_COUNT_WIDTH)
  ) u_core (
    .clk                (clk),
    .rst                (rst),
    .in_accept          (accept),
    .button             (s_tdata[0]),
    .period_ticks       (period_ticks),
    .long_press_periods (long_press_periods),
    .ramp_divider       (ramp_divider),
    .result             (result)
  );

  brpd_skid #(
    .DATA_W (RES_W)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  // Pad the result to whole bytes
  assign m_tdata = OUT_W'(out_res);

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  import brpd_pkg::*;

  localparam int PERIOD_W       = DEF_PERIOD_WIDTH;
  localparam int PRESS_W        = DEF_PRESS_COUNT_WIDTH;
  localparam int CFG_W          = (PERIOD_W > PRESS_W) ? PERIOD_W : PRESS_W;
  localparam int RANDOM_TICKS   = 1100;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  // One output item as it sits in m_tdata, lowest bit first: led, duty, mode
  typedef struct packed {
    ramp_mode_t          mode;
    logic [PERIOD_W-1:0] brightness;
    logic                led;
  } dimmer_out_t;

  typedef enum {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    int unsigned           value;
    bit                    typed;
    dimmer_out_t           want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;    // button
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;         // led_on, brightness, ramp_mode
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Predictor copy of the registers and the dimmer state
  logic [PERIOD_W-1:0] period_cfg = PERIOD_W'(RST_PERIOD_TICKS);
  logic [PRESS_W-1:0]  long_press_cfg = PRESS_W'(RST_LONG_PRESS_PERIODS);
  logic [7:0]          divider_cfg = 8'(RST_RAMP_DIVIDER);
  logic [PERIOD_W-1:0] tick_pos = '0;
  logic [PERIOD_W-1:0] duty = PERIOD_W'(RST_DUTY_TICKS);
  logic [PRESS_W-1:0]  press_count = '0;
  logic                going_up = 1'b0;
  logic                going_down = 1'b0;
  logic [7:0]          step_count = '0;

  dimmer_out_t pending_outputs[$];
  dimmer_out_t typed_out;
  bit          typed_valid = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned ticks_accepted = 0;
  int unsigned cfg_writes = 0;
  int unsigned steps_predicted = 0;
  int unsigned quiet_cycles = 0;
  int unsigned holdoff_requests = 0;
  int unsigned holdoff_served = 0;
  int unsigned burst_left = 0;
  bit          steady_sender = 1'b0;

  button_ramped_pwm_dimmer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the dimmer by one base tick and return what the block must show
  function automatic dimmer_out_t dimmer_predict(input bit pressed);
    dimmer_out_t res;
    res.led = (tick_pos < duty);
    if (int'(tick_pos) + 1 >= int'(period_cfg)) begin
      tick_pos = '0;
      // Sample the button at the end of the period
      if (pressed) begin
        if (press_count != '1) press_count = press_count + 1'b1;
      end else if (press_count != '0) begin
        if (going_up || going_down) begin
          going_up = 1'b0;
          going_down = 1'b0;
        end else if (press_count > long_press_cfg) begin
          going_down = 1'b1;
        end else begin
          going_up = 1'b1;
        end
        press_count = '0;
      end
      // Move the duty one step every divider periods
      if (going_up || going_down) begin
        step_count = step_count + 8'd1;
        if (step_count == divider_cfg) begin
          steps_predicted++;
          if (going_up) begin
            if (duty < period_cfg) duty = duty + 1'b1;
            else going_up = 1'b0;
          end else begin
            if (duty != '0) duty = duty - 1'b1;
            else going_down = 1'b0;
          end
          step_count = '0;
        end
      end
    end else begin
      tick_pos = tick_pos + 1'b1;
    end
    res.brightness = duty;
    res.mode = going_up ? RAMP_UP : (going_down ? RAMP_DOWN : RAMP_IDLE);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at output %0d, %s: got %0d, expected %0d",
             results_checked, what, got, want);
    mismatch_count++;
  endtask

  // Check outputs against the oldest expectation, predict each accepted tick
  always @(posedge clk) begin
    dimmer_out_t got;
    dimmer_out_t want;
    dimmer_out_t pred;
    if (!rst) begin
      quiet_cycles++;
      if (m_tvalid && m_tready) begin
        quiet_cycles = 0;
        got = m_tdata[$bits(dimmer_out_t)-1:0];
        if (pending_outputs.size() == 0) begin
          report_mismatch("output with nothing pending", int'(got), 0);
        end else begin
          want = pending_outputs.pop_front();
          if (got.led !== want.led) report_mismatch("led_on", got.led, want.led);
          if (got.brightness !== want.brightness)
            report_mismatch("brightness", got.brightness, want.brightness);
          if (got.mode !== want.mode) report_mismatch("ramp_mode", got.mode, want.mode);
        end
        results_checked++;
      end
      if (s_tvalid && s_tready) begin
        quiet_cycles = 0;
        pred = dimmer_predict(s_tdata[0]);
        pending_outputs.push_back(typed_valid ? typed_out : pred);
        ticks_accepted++;
      end
      if (cfg_we) quiet_cycles = 0;
    end
  end

  // Stop a run that makes no progress
  always @(negedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: stall pattern changes in spans, long hold-off on request
  initial begin : receiver
    int unsigned level;
    int unsigned span;
    level = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (holdoff_requests != holdoff_served) begin
        holdoff_served++;
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      if (span == 0) begin
        level = $urandom_range(0, 2);
        span = $urandom_range(16, 96);
      end
      span--;
      case (level)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Offer one tick in bursts with random gaps; entered and left at a falling edge
  task automatic send_tick(input bit btn);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = steady_sender ? 400 : $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, btn};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    @(negedge clk);
    typed_valid = 1'b0;
  endtask

  // Drop valid and wait until every pending output has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_outputs.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      CFG_PERIOD_TICKS:       period_cfg = value[PERIOD_W-1:0];
      CFG_LONG_PRESS_PERIODS: long_press_cfg = value[PRESS_W-1:0];
      CFG_RAMP_DIVIDER:       divider_cfg = value[7:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Mostly well-formed presses of chosen length, then releases; some noise
  task automatic run_phase(input int unsigned budget, output int unsigned sent);
    int unsigned pe;
    int unsigned periods;
    int unsigned hold;
    int unsigned rel;
    int unsigned lp;
    sent = 0;
    while (sent < budget) begin
      pe = (period_cfg == '0) ? 1 : period_cfg;
      lp = long_press_cfg;
      if ($urandom_range(0, 9) < 7) begin
        if (pe > 100) periods = $urandom_range(1, 2);
        else if ($urandom_range(0, 1)) periods = $urandom_range(1, (lp < 8) ? lp + 1 : 8);
        else if (lp < 60) periods = lp + $urandom_range(1, 4);
        else periods = $urandom_range(1, 8);
        hold = periods * pe + $urandom_range(0, pe - 1);
        rel = pe * $urandom_range(1, (pe > 100) ? 1 : 6) + $urandom_range(0, pe - 1);
        repeat (hold) send_tick(1'b1);
        repeat (rel) send_tick(1'b0);
        sent += hold + rel;
      end else begin
        hold = $urandom_range(1, 12);
        repeat (hold) send_tick($urandom_range(0, 1));
        sent += hold;
      end
    end
  endtask

  function automatic dir_row_t tick_row(input bit btn);
    dir_row_t r;
    r.kind = ROW_TICK;
    r.addr = '0;
    r.value = btn;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input bit btn, input bit led,
                                         input int unsigned br, input ramp_mode_t m);
    dir_row_t r;
    r = tick_row(btn);
    r.typed = 1'b1;
    r.want.led = led;
    r.want.brightness = PERIOD_W'(br);
    r.want.mode = m;
    return r;
  endfunction

  function automatic dir_row_t write_row(input logic [CFG_ADDR_W-1:0] addr,
                                         input int unsigned value);
    dir_row_t r;
    r = tick_row(1'b0);
    r.kind = ROW_WRITE;
    r.addr = addr;
    r.value = value;
    return r;
  endfunction

  initial begin : stimulus
    dir_row_t    dir_table[$];
    int unsigned random_ticks;
    int unsigned sent;
    int unsigned phase;
    int unsigned roll;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    dir_table = '{
      // first tick after reset: position 0 under the reset duty of one
      typed_row(1'b0, 1'b1, RST_DUTY_TICKS, RAMP_IDLE),
      // shrink the period below the current position: period ends at once
      write_row(CFG_PERIOD_TICKS, 1),
      write_row(CFG_RAMP_DIVIDER, 1),
      write_row(CFG_LONG_PRESS_PERIODS, 0),
      tick_row(1'b1),
      // any press beats a zero limit: ramp down, then stop at zero duty
      typed_row(1'b0, 1'b1, 0, RAMP_DOWN),
      typed_row(1'b0, 1'b0, 0, RAMP_IDLE),
      // release with no press counted does nothing
      tick_row(1'b0),
      write_row(CFG_LONG_PRESS_PERIODS, 65535),
      tick_row(1'b1),
      typed_row(1'b0, 1'b0, 1, RAMP_UP),
      typed_row(1'b0, 1'b1, 1, RAMP_IDLE),
      // zero period: every tick ends a period, duty already above it
      write_row(CFG_PERIOD_TICKS, 0),
      tick_row(1'b1),
      tick_row(1'b0),
      // zero divider waits for the counter wrap; a second press stops the ramp
      write_row(CFG_RAMP_DIVIDER, 0),
      tick_row(1'b1),
      tick_row(1'b0),
      tick_row(1'b0),
      tick_row(1'b1),
      tick_row(1'b0),
      write_row(CFG_PERIOD_TICKS, 1023),
      write_row(CFG_RAMP_DIVIDER, 255),
      tick_row(1'b1),
      tick_row(1'b0)
    };

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WRITE) begin
        write_reg(dir_table[i].addr, dir_table[i].value);
      end else begin
        typed_valid = dir_table[i].typed;
        typed_out = dir_table[i].want;
        send_tick(dir_table[i].value[0]);
      end
    end

    // A 25-tick period with the shortest limit and divider
    write_reg(CFG_PERIOD_TICKS, 25);
    write_reg(CFG_LONG_PRESS_PERIODS, 0);
    write_reg(CFG_RAMP_DIVIDER, 1);
    run_phase(300, sent);

    // Random settings, mostly short periods
    random_ticks = 0;
    phase = 0;
    while (random_ticks < RANDOM_TICKS) begin
      roll = $urandom_range(0, 9);
      if (phase == 0 || $urandom_range(0, 1))
        write_reg(CFG_PERIOD_TICKS, (roll < 6) ? $urandom_range(1, 4) :
                                    (roll < 9) ? $urandom_range(5, 20) : 0);
      roll = $urandom_range(0, 9);
      if (phase == 0 || $urandom_range(0, 1))
        write_reg(CFG_LONG_PRESS_PERIODS, (roll < 7) ? $urandom_range(0, 5) :
                                          (roll < 9) ? $urandom_range(6, 20) : 65535);
      roll = $urandom_range(0, 9);
      if (phase == 0 || $urandom_range(0, 1))
        write_reg(CFG_RAMP_DIVIDER, (roll < 8) ? $urandom_range(1, 3) :
                                    (roll < 9) ? 0 : 255);
      steady_sender = ($urandom_range(0, 3) == 0);
      if (phase == 1 || $urandom_range(0, 6) == 0) holdoff_requests++;
      run_phase($urandom_range(80, 160), sent);
      random_ticks += sent;
      phase++;
    end

    wait_drained();
    repeat (8) @(negedge clk);
    $display("Covered %0d ticks over %0d register writes, with zero, one-tick and widest",
             ticks_accepted, cfg_writes);
    $display("periods under stalls and a long hold-off; %0d outputs compared, %0d duty steps.",
             results_checked, steps_predicted);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/brpd_pkg.sv
src/brpd_cfg.sv
src/brpd_core.sv
src/brpd_skid.sv
src/button_ramped_pwm_dimmer.sv
tb/sv/testbench.sv
